FILE: src/otq_pkg.sv
// Shared types, constants and helper functions for the outline to quadratic curve block.
`timescale 1ns / 1ps

package otq_pkg;

    localparam int FRAC_BITS_DEF  = 8;
    localparam int BAND_COUNT_DEF = 8;
    localparam int COORD_W        = 16;
    localparam int POINT_W        = 24;
    localparam int BAND_W         = 3;
    localparam int WIDE_W         = 40;
    localparam int REG_IDX_W      = 2;

    localparam logic [2:0] OP_MOVE  = 3'd0;
    localparam logic [2:0] OP_LINE  = 3'd1;
    localparam logic [2:0] OP_QUAD  = 3'd2;
    localparam logic [2:0] OP_CUBIC = 3'd3;
    localparam logic [2:0] OP_END   = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_BOX_X_MIN = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOX_Y_MIN = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOX_X_MAX = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOX_Y_MAX = 2'd3;

    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam wide_t PT_MAX = 40'sd8388607;
    localparam wide_t PT_MIN = -40'sd8388608;

    typedef struct packed {
        logic [2:0]                opcode;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] ctrl_a_x;
        logic signed [COORD_W-1:0] ctrl_a_y;
        logic signed [COORD_W-1:0] ctrl_b_x;
        logic signed [COORD_W-1:0] ctrl_b_y;
    } in_word_t;

    typedef struct packed {
        logic signed [POINT_W-1:0] start_px;
        logic signed [POINT_W-1:0] start_py;
        logic signed [POINT_W-1:0] mid_px;
        logic signed [POINT_W-1:0] mid_py;
        logic signed [POINT_W-1:0] stop_px;
        logic signed [POINT_W-1:0] stop_py;
        logic [BAND_W-1:0]         hband_lo;
        logic [BAND_W-1:0]         hband_hi;
        logic [BAND_W-1:0]         vband_lo;
        logic [BAND_W-1:0]         vband_hi;
        logic                      bands_valid;
        logic                      last;
    } out_word_t;

    typedef struct packed {
        logic signed [POINT_W-1:0] coord;
        logic signed [COORD_W-1:0] lo;
        logic [COORD_W-1:0]        size;
    } band_req_t;

    function automatic wide_t sext16(input logic [COORD_W-1:0] v);
        return {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic wide_t sext24(input logic [POINT_W-1:0] v);
        return {{(WIDE_W-POINT_W){v[POINT_W-1]}}, v};
    endfunction

    function automatic logic signed [POINT_W-1:0] sat_point(input wide_t v);
        logic signed [POINT_W-1:0] r;
        if (v > PT_MAX) begin
            r = PT_MAX[POINT_W-1:0];
        end else if (v < PT_MIN) begin
            r = PT_MIN[POINT_W-1:0];
        end else begin
            r = v[POINT_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: src/otq_push.sv
// Iterative unit for the sideways push of a diagonal line: squares, long division and root search.
`timescale 1ns / 1ps

module otq_push #(
    parameter int FRAC_BITS = otq_pkg::FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [15:0]          adx,
    input  logic [15:0]          ady,
    output logic                 done,
    output logic [FRAC_BITS-2:0] mag_x,
    output logic [FRAC_BITS-2:0] mag_y
);

    localparam int QW   = 2 * FRAC_BITS - 3;
    localparam int NW   = FRAC_BITS - 1;
    localparam int SW   = 33;
    localparam int RW   = SW + 1;
    localparam int CNTW = $clog2(QW + 1);

    typedef enum logic [2:0] {P_IDLE, P_SQX, P_SQY, P_SUM, P_DIV, P_ROOT, P_DONE} pstate_t;

    pstate_t         state_reg;
    logic [15:0]     adx_reg, ady_reg;
    logic [31:0]     sqx_reg, sqy_reg;
    logic [SW-1:0]   s_reg;
    logic [RW-1:0]   rem_reg;
    logic [QW-1:0]   shin_reg, quo_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [NW-1:0]   mask_reg, root_reg, mag_x_reg, mag_y_reg;
    logic            pass_reg, done_reg;

    logic [15:0]     mul_a, mul_b;
    logic [31:0]     prod;
    logic [RW-1:0]   trial;
    logic            fits;
    logic [NW-1:0]   cand, root_next;
    logic [NW:0]     odd_t;
    logic            root_ok;

    assign trial     = {rem_reg[RW-2:0], shin_reg[QW-1]};
    assign fits      = trial >= {1'b0, s_reg};
    assign cand      = root_reg | mask_reg;
    assign odd_t     = {cand, 1'b0} - 1'b1;
    assign prod      = mul_a * mul_b;
    assign root_ok   = prod <= 32'(quo_reg);
    assign root_next = root_ok ? cand : root_reg;

    always_comb begin
        unique case (state_reg)
            P_SQX: begin
                mul_a = adx_reg;
                mul_b = adx_reg;
            end
            P_SQY: begin
                mul_a = ady_reg;
                mul_b = ady_reg;
            end
            P_ROOT: begin
                mul_a = 16'(odd_t);
                mul_b = 16'(odd_t);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
            pass_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                P_IDLE: begin
                    if (start) begin
                        adx_reg   <= adx;
                        ady_reg   <= ady;
                        state_reg <= P_SQX;
                    end
                end
                P_SQX: begin
                    sqx_reg   <= prod;
                    state_reg <= P_SQY;
                end
                P_SQY: begin
                    sqy_reg   <= prod;
                    state_reg <= P_SUM;
                end
                P_SUM: begin
                    s_reg     <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
                    rem_reg   <= RW'(sqy_reg >> 1);
                    shin_reg  <= {sqy_reg[0], {(QW-1){1'b0}}};
                    quo_reg   <= '0;
                    cnt_reg   <= CNTW'(QW);
                    pass_reg  <= 1'b0;
                    state_reg <= P_DIV;
                end
                P_DIV: begin
                    rem_reg  <= fits ? trial - {1'b0, s_reg} : trial;
                    quo_reg  <= {quo_reg[QW-2:0], fits};
                    shin_reg <= shin_reg << 1;
                    cnt_reg  <= cnt_reg - 1'b1;
                    if (cnt_reg == CNTW'(1)) begin
                        root_reg  <= '0;
                        mask_reg  <= {1'b1, {(NW-1){1'b0}}};
                        state_reg <= P_ROOT;
                    end
                end
                P_ROOT: begin
                    root_reg <= root_next;
                    mask_reg <= mask_reg >> 1;
                    if (mask_reg[0]) begin
                        if (!pass_reg) begin
                            mag_x_reg <= root_next;
                            pass_reg  <= 1'b1;
                            rem_reg   <= RW'(sqx_reg >> 1);
                            shin_reg  <= {sqx_reg[0], {(QW-1){1'b0}}};
                            quo_reg   <= '0;
                            cnt_reg   <= CNTW'(QW);
                            state_reg <= P_DIV;
                        end else begin
                            mag_y_reg <= root_next;
                            state_reg <= P_DONE;
                        end
                    end
                end
                P_DONE: begin
                    done_reg  <= 1'b1;
                    state_reg <= P_IDLE;
                end
                default: state_reg <= P_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign mag_x = mag_x_reg;
    assign mag_y = mag_y_reg;

endmodule

FILE: src/otq_band.sv
// Iterative band index unit: counts the band edges that a coordinate reaches inside the glyph box.
`timescale 1ns / 1ps

module otq_band #(
    parameter int FRAC_BITS  = otq_pkg::FRAC_BITS_DEF,
    parameter int BAND_COUNT = otq_pkg::BAND_COUNT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  otq_pkg::band_req_t         req,
    output logic                       done,
    output logic [otq_pkg::BAND_W-1:0] band
);

    localparam int CW   = $clog2(BAND_COUNT);
    localparam int NUMW = FRAC_BITS + 26 + CW;

    typedef enum logic [1:0] {B_IDLE, B_STEP, B_DONE} bstate_t;

    bstate_t                   state_reg;
    logic signed [NUMW-1:0]    num_reg, den_reg, thr_reg;
    logic [CW-1:0]             cnt_reg, k_reg;
    logic [otq_pkg::BAND_W-1:0] band_reg;
    logic                      done_reg;

    otq_pkg::wide_t            diff_w;
    logic signed [NUMW-1:0]    num_w, den_w;

    assign diff_w = otq_pkg::sext24(req.coord) - (otq_pkg::sext16(req.lo) <<< FRAC_BITS);
    assign num_w  = NUMW'(diff_w) * NUMW'(BAND_COUNT);
    assign den_w  = signed'(NUMW'(req.size) << FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE: begin
                    if (start) begin
                        num_reg   <= num_w;
                        den_reg   <= den_w;
                        thr_reg   <= den_w;
                        cnt_reg   <= '0;
                        k_reg     <= CW'(1);
                        state_reg <= B_STEP;
                    end
                end
                B_STEP: begin
                    if (num_reg >= thr_reg) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    thr_reg <= thr_reg + den_reg;
                    k_reg   <= k_reg + 1'b1;
                    if (k_reg == CW'(BAND_COUNT - 1)) begin
                        state_reg <= B_DONE;
                    end
                end
                B_DONE: begin
                    band_reg  <= otq_pkg::BAND_W'(cnt_reg);
                    done_reg  <= 1'b1;
                    state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign band = band_reg;

endmodule

FILE: src/outline_to_quadratic_curves_core.sv
// Top level of the outline to quadratic curve block: command sequencer, contour state and result register.
`timescale 1ns / 1ps

// Usage: outline commands enter on the s_ channel, one word per command, and quadratic
// curves leave on the m_ channel, one word per curve, with last set on the final curve
// of a command. A move or end gives one closing line or none, a cubic gives two, a line or
// quad gives one, and other opcodes give none. The glyph box is written through cfg_we,
// cfg_index and cfg_data; the user must do so only while the block is idle, which the block
// itself does not enforce. One command is worked on at a time; s_ready is low from acceptance
// until its last curve has been taken. Each curve, when the box is not empty, passes through
// the band unit for its four band indices; a diagonal line also passes through the push unit
// for its division and root search. A result stays on m_data with m_valid high until m_ready;
// the sequencer waits meanwhile. Reset, synchronous and active low on aresetn, clears the box,
// the current point, the contour start and the open contour flag, and drops m_valid.

module outline_to_quadratic_curves_core #(
    parameter int FRAC_BITS  = otq_pkg::FRAC_BITS_DEF,
    parameter int BAND_COUNT = otq_pkg::BAND_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  otq_pkg::in_word_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output otq_pkg::out_word_t            m_data,
    input  logic                          cfg_we,
    input  logic [otq_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [otq_pkg::COORD_W-1:0]   cfg_data
);

    localparam int NW = FRAC_BITS - 1;

    localparam logic [1:0] BAND_Y_LO = 2'd0;
    localparam logic [1:0] BAND_Y_HI = 2'd1;
    localparam logic [1:0] BAND_X_LO = 2'd2;
    localparam logic [1:0] BAND_X_HI = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_LINE, S_PUSH, S_BUILD, S_BAND_GO, S_BAND_WAIT, S_OUT
    } state_t;

    typedef enum logic [1:0] {K_LINE, K_QUAD, K_CUB1, K_CUB2} kind_t;

    state_t             state_reg;
    kind_t              kind_reg;
    otq_pkg::in_word_t  in_reg;
    otq_pkg::out_word_t out_reg;
    logic               m_valid_reg, push_start_reg, band_start_reg;
    logic [1:0]         band_idx_reg;
    logic [15:0]        cur_x_reg, cur_y_reg, org_x_reg, org_y_reg;
    logic               open_reg;
    logic [15:0]        cur_x_next, cur_y_next, org_x_next, org_y_next;
    logic               open_next;
    logic [15:0]        box_x_min_reg, box_y_min_reg, box_x_max_reg, box_y_max_reg;
    logic [15:0]        lx0_reg, ly0_reg, lx1_reg, ly1_reg;
    logic [NW-1:0]      ox_reg, oy_reg;

    logic signed [16:0] box_w, box_h, dx_w, dy_w;
    logic               bands_ok, diag, dx_pos, dy_pos;
    logic [15:0]        adx, ady;
    logic               push_done, band_done;
    logic [NW-1:0]      mag_x, mag_y;
    logic [otq_pkg::BAND_W-1:0] band_val;
    otq_pkg::band_req_t band_req;

    otq_pkg::wide_t cx, cy, ax, ay, bx, by, ex, ey, l0x, l0y, l1x, l1y, offx, offy;
    otq_pkg::wide_t mx, my;
    otq_pkg::wide_t p0, p1, p2, p3, p4, p5;

    function automatic logic signed [23:0] min3(input logic signed [23:0] a,
                                                input logic signed [23:0] b,
                                                input logic signed [23:0] c);
        logic signed [23:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [23:0] max3(input logic signed [23:0] a,
                                                input logic signed [23:0] b,
                                                input logic signed [23:0] c);
        logic signed [23:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    assign box_w    = {box_x_max_reg[15], box_x_max_reg} - {box_x_min_reg[15], box_x_min_reg};
    assign box_h    = {box_y_max_reg[15], box_y_max_reg} - {box_y_min_reg[15], box_y_min_reg};
    assign bands_ok = !box_w[16] && (box_w != '0) && !box_h[16] && (box_h != '0);

    assign dx_w   = {lx1_reg[15], lx1_reg} - {lx0_reg[15], lx0_reg};
    assign dy_w   = {ly1_reg[15], ly1_reg} - {ly0_reg[15], ly0_reg};
    assign adx    = dx_w[16] ? 16'(-dx_w) : dx_w[15:0];
    assign ady    = dy_w[16] ? 16'(-dy_w) : dy_w[15:0];
    assign diag   = (dx_w != '0) && (dy_w != '0);
    assign dx_pos = !dx_w[16] && (dx_w != '0);
    assign dy_pos = !dy_w[16] && (dy_w != '0);

    always_comb begin
        cx   = otq_pkg::sext16(cur_x_reg);
        cy   = otq_pkg::sext16(cur_y_reg);
        ax   = otq_pkg::sext16(in_reg.ctrl_a_x);
        ay   = otq_pkg::sext16(in_reg.ctrl_a_y);
        bx   = otq_pkg::sext16(in_reg.ctrl_b_x);
        by   = otq_pkg::sext16(in_reg.ctrl_b_y);
        ex   = otq_pkg::sext16(in_reg.end_x);
        ey   = otq_pkg::sext16(in_reg.end_y);
        l0x  = otq_pkg::sext16(lx0_reg);
        l0y  = otq_pkg::sext16(ly0_reg);
        l1x  = otq_pkg::sext16(lx1_reg);
        l1y  = otq_pkg::sext16(ly1_reg);
        offx = {{(otq_pkg::WIDE_W-NW){1'b0}}, ox_reg};
        offy = {{(otq_pkg::WIDE_W-NW){1'b0}}, oy_reg};
        mx   = (cx + (ax <<< 1) + ax + (bx <<< 1) + bx + ex) <<< (FRAC_BITS - 3);
        my   = (cy + (ay <<< 1) + ay + (by <<< 1) + by + ey) <<< (FRAC_BITS - 3);
        case (kind_reg)
            K_LINE: begin
                p0 = l0x <<< FRAC_BITS;
                p1 = l0y <<< FRAC_BITS;
                p2 = ((l0x + l1x) <<< (FRAC_BITS - 1)) + (dy_pos ? -offx : offx);
                p3 = ((l0y + l1y) <<< (FRAC_BITS - 1)) + (dx_pos ? offy : -offy);
                p4 = l1x <<< FRAC_BITS;
                p5 = l1y <<< FRAC_BITS;
            end
            K_QUAD: begin
                p0 = cx <<< FRAC_BITS;
                p1 = cy <<< FRAC_BITS;
                p2 = ax <<< FRAC_BITS;
                p3 = ay <<< FRAC_BITS;
                p4 = ex <<< FRAC_BITS;
                p5 = ey <<< FRAC_BITS;
            end
            K_CUB1: begin
                p0 = cx <<< FRAC_BITS;
                p1 = cy <<< FRAC_BITS;
                p2 = (cx + ax) <<< (FRAC_BITS - 1);
                p3 = (cy + ay) <<< (FRAC_BITS - 1);
                p4 = mx;
                p5 = my;
            end
            default: begin
                p0 = mx;
                p1 = my;
                p2 = (ax + (bx <<< 1) + ex) <<< (FRAC_BITS - 2);
                p3 = (ay + (by <<< 1) + ey) <<< (FRAC_BITS - 2);
                p4 = ex <<< FRAC_BITS;
                p5 = ey <<< FRAC_BITS;
            end
        endcase
    end

    always_comb begin
        unique case (band_idx_reg)
            BAND_Y_LO: begin
                band_req.coord = min3(out_reg.start_py, out_reg.mid_py, out_reg.stop_py);
                band_req.lo    = box_y_min_reg;
                band_req.size  = box_h[15:0];
            end
            BAND_Y_HI: begin
                band_req.coord = max3(out_reg.start_py, out_reg.mid_py, out_reg.stop_py);
                band_req.lo    = box_y_min_reg;
                band_req.size  = box_h[15:0];
            end
            BAND_X_LO: begin
                band_req.coord = min3(out_reg.start_px, out_reg.mid_px, out_reg.stop_px);
                band_req.lo    = box_x_min_reg;
                band_req.size  = box_w[15:0];
            end
            default: begin
                band_req.coord = max3(out_reg.start_px, out_reg.mid_px, out_reg.stop_px);
                band_req.lo    = box_x_min_reg;
                band_req.size  = box_w[15:0];
            end
        endcase
    end

    always_comb begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        org_x_next = org_x_reg;
        org_y_next = org_y_reg;
        open_next  = open_reg;
        unique case (in_reg.opcode) inside
            otq_pkg::OP_MOVE: begin
                cur_x_next = in_reg.end_x;
                cur_y_next = in_reg.end_y;
                org_x_next = in_reg.end_x;
                org_y_next = in_reg.end_y;
                open_next  = 1'b1;
            end
            otq_pkg::OP_END: begin
                cur_x_next = '0;
                cur_y_next = '0;
                org_x_next = '0;
                org_y_next = '0;
                open_next  = 1'b0;
            end
            otq_pkg::OP_LINE, otq_pkg::OP_QUAD, otq_pkg::OP_CUBIC: begin
                cur_x_next = in_reg.end_x;
                cur_y_next = in_reg.end_y;
            end
            default: begin
                open_next = open_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_x_min_reg <= '0;
            box_y_min_reg <= '0;
            box_x_max_reg <= '0;
            box_y_max_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                otq_pkg::REG_BOX_X_MIN: box_x_min_reg <= cfg_data;
                otq_pkg::REG_BOX_Y_MIN: box_y_min_reg <= cfg_data;
                otq_pkg::REG_BOX_X_MAX: box_x_max_reg <= cfg_data;
                otq_pkg::REG_BOX_Y_MAX: box_y_max_reg <= cfg_data;
                default: box_x_min_reg <= box_x_min_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            push_start_reg <= 1'b0;
            band_start_reg <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            org_x_reg      <= '0;
            org_y_reg      <= '0;
            open_reg       <= 1'b0;
        end else begin
            push_start_reg <= 1'b0;
            band_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    unique case (in_reg.opcode) inside
                        otq_pkg::OP_MOVE, otq_pkg::OP_END: begin
                            if (open_reg && ((cur_x_reg != org_x_reg) ||
                                             (cur_y_reg != org_y_reg))) begin
                                lx0_reg   <= cur_x_reg;
                                ly0_reg   <= cur_y_reg;
                                lx1_reg   <= org_x_reg;
                                ly1_reg   <= org_y_reg;
                                kind_reg  <= K_LINE;
                                state_reg <= S_LINE;
                            end else begin
                                cur_x_reg <= cur_x_next;
                                cur_y_reg <= cur_y_next;
                                org_x_reg <= org_x_next;
                                org_y_reg <= org_y_next;
                                open_reg  <= open_next;
                                state_reg <= S_IDLE;
                            end
                        end
                        otq_pkg::OP_LINE: begin
                            lx0_reg   <= cur_x_reg;
                            ly0_reg   <= cur_y_reg;
                            lx1_reg   <= in_reg.end_x;
                            ly1_reg   <= in_reg.end_y;
                            kind_reg  <= K_LINE;
                            state_reg <= S_LINE;
                        end
                        otq_pkg::OP_QUAD: begin
                            kind_reg  <= K_QUAD;
                            state_reg <= S_BUILD;
                        end
                        otq_pkg::OP_CUBIC: begin
                            kind_reg  <= K_CUB1;
                            state_reg <= S_BUILD;
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_LINE: begin
                    if (diag) begin
                        push_start_reg <= 1'b1;
                        state_reg      <= S_PUSH;
                    end else begin
                        ox_reg    <= '0;
                        oy_reg    <= '0;
                        state_reg <= S_BUILD;
                    end
                end
                S_PUSH: begin
                    if (push_done) begin
                        ox_reg    <= mag_x;
                        oy_reg    <= mag_y;
                        state_reg <= S_BUILD;
                    end
                end
                S_BUILD: begin
                    out_reg.start_px    <= otq_pkg::sat_point(p0);
                    out_reg.start_py    <= otq_pkg::sat_point(p1);
                    out_reg.mid_px      <= otq_pkg::sat_point(p2);
                    out_reg.mid_py      <= otq_pkg::sat_point(p3);
                    out_reg.stop_px     <= otq_pkg::sat_point(p4);
                    out_reg.stop_py     <= otq_pkg::sat_point(p5);
                    out_reg.bands_valid <= bands_ok;
                    out_reg.last        <= (kind_reg != K_CUB1);
                    if (bands_ok) begin
                        band_idx_reg <= BAND_Y_LO;
                        state_reg    <= S_BAND_GO;
                    end else begin
                        out_reg.hband_lo <= '0;
                        out_reg.hband_hi <= '0;
                        out_reg.vband_lo <= '0;
                        out_reg.vband_hi <= '0;
                        m_valid_reg      <= 1'b1;
                        state_reg        <= S_OUT;
                    end
                end
                S_BAND_GO: begin
                    band_start_reg <= 1'b1;
                    state_reg      <= S_BAND_WAIT;
                end
                S_BAND_WAIT: begin
                    if (band_done) begin
                        case (band_idx_reg)
                            BAND_Y_LO: out_reg.hband_lo <= band_val;
                            BAND_Y_HI: out_reg.hband_hi <= band_val;
                            BAND_X_LO: out_reg.vband_lo <= band_val;
                            default:   out_reg.vband_hi <= band_val;
                        endcase
                        if (band_idx_reg == BAND_X_HI) begin
                            m_valid_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end else begin
                            band_idx_reg <= band_idx_reg + 1'b1;
                            state_reg    <= S_BAND_GO;
                        end
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (kind_reg == K_CUB1) begin
                            kind_reg  <= K_CUB2;
                            state_reg <= S_BUILD;
                        end else begin
                            cur_x_reg <= cur_x_next;
                            cur_y_reg <= cur_y_next;
                            org_x_reg <= org_x_next;
                            org_y_reg <= org_y_next;
                            open_reg  <= open_next;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    otq_push #(
        .FRAC_BITS(FRAC_BITS)
    ) u_push (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (push_start_reg),
        .adx     (adx),
        .ady     (ady),
        .done    (push_done),
        .mag_x   (mag_x),
        .mag_y   (mag_y)
    );

    otq_band #(
        .FRAC_BITS  (FRAC_BITS),
        .BAND_COUNT (BAND_COUNT)
    ) u_band (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (band_start_reg),
        .req     (band_req),
        .done    (band_done),
        .band    (band_val)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: src/otq_checker.sv
// Port-level assertions for the outline to quadratic curve block and the bind that attaches them.
`timescale 1ns / 1ps

module otq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input otq_pkg::in_word_t             s_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input otq_pkg::out_word_t            m_data,
    input logic                          cfg_we,
    input logic [otq_pkg::REG_IDX_W-1:0] cfg_index,
    input logic [otq_pkg::COORD_W-1:0]   cfg_data
);

    // A result word waiting for the receiver keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // The block never takes a command while a curve is still on offer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // The block drops s_ready in the cycle after it takes a command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after acceptance");

    // With an empty glyph box all band fields read zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.bands_valid |->
            (m_data.hband_lo == '0) && (m_data.hband_hi == '0) &&
            (m_data.vband_lo == '0) && (m_data.vband_hi == '0))
        else $error("band fields set for an empty box");

    // Reset drops any pending result.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind outline_to_quadratic_curves_core otq_checker u_otq_checker (.*);

FILE: bench/tb_outline_to_quadratic_curves_core.sv
// Testbench for the outline to quadratic curve block: directed and random outlines against a built-in predictor.
`timescale 1ns / 1ps

module tb_outline_to_quadratic_curves_core;

    localparam int FB = 8;
    localparam int BC = 8;
    localparam longint SC = 64'sd1 << FB;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    otq_pkg::in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    otq_pkg::out_word_t m_data;
    logic cfg_we = 1'b0;
    logic [otq_pkg::REG_IDX_W-1:0] cfg_index = otq_pkg::REG_BOX_X_MIN;
    logic [otq_pkg::COORD_W-1:0] cfg_data = '0;

    int mismatches = 0;
    bit stim_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    outline_to_quadratic_curves_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic void report(input string what, input longint got, input longint want);
        $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endfunction

    class curve_scoreboard;
        longint bx0, by0, bx1, by1;
        longint cur_x, cur_y, org_x, org_y;
        bit open;
        otq_pkg::out_word_t pending[$];

        function new();
            bx0 = 0; by0 = 0; bx1 = 0; by1 = 0;
            cur_x = 0; cur_y = 0; org_x = 0; org_y = 0; open = 0;
        endfunction

        function void set_box(input logic [otq_pkg::REG_IDX_W-1:0] idx, input logic [15:0] v);
            longint s;
            s = longint'($signed(v));
            case (idx)
                otq_pkg::REG_BOX_X_MIN: bx0 = s;
                otq_pkg::REG_BOX_Y_MIN: by0 = s;
                otq_pkg::REG_BOX_X_MAX: bx1 = s;
                default: by1 = s;
            endcase
        endfunction

        function longint clamp24(input longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function logic [2:0] band(input longint c, input longint lo, input longint sz);
            longint num, den, q;
            num = (c - lo * SC) * BC;
            den = sz * SC;
            q = num / den;
            if ((num % den) != 0 && num < 0) q--;
            if (q < 0) q = 0;
            if (q > BC - 1) q = BC - 1;
            return q[2:0];
        endfunction

        function longint push(input longint a, input longint s);
            longint lim, n, c, t;
            lim = ((a * a) << (2 * FB - 4)) / s;
            n = 0;
            for (int b = FB - 2; b >= 0; b--) begin
                c = n | (64'sd1 << b);
                t = 2 * c - 1;
                if (t * t <= lim) n = c;
            end
            return n;
        endfunction

        function void add_curve(input longint p[6]);
            otq_pkg::out_word_t w;
            longint q[6];
            longint wd, ht, mnx, mxx, mny, mxy;
            for (int i = 0; i < 6; i++) q[i] = clamp24(p[i]);
            w = '0;
            w.start_px = q[0][23:0]; w.start_py = q[1][23:0];
            w.mid_px = q[2][23:0]; w.mid_py = q[3][23:0];
            w.stop_px = q[4][23:0]; w.stop_py = q[5][23:0];
            wd = bx1 - bx0;
            ht = by1 - by0;
            if (wd > 0 && ht > 0) begin
                mnx = q[0]; mxx = q[0]; mny = q[1]; mxy = q[1];
                for (int i = 2; i < 6; i += 2) begin
                    if (q[i] < mnx) mnx = q[i];
                    if (q[i] > mxx) mxx = q[i];
                    if (q[i+1] < mny) mny = q[i+1];
                    if (q[i+1] > mxy) mxy = q[i+1];
                end
                w.hband_lo = band(mny, by0, ht);
                w.hband_hi = band(mxy, by0, ht);
                w.vband_lo = band(mnx, bx0, wd);
                w.vband_hi = band(mxx, bx0, wd);
                w.bands_valid = 1'b1;
            end
            pending.push_back(w);
        endfunction

        function void add_line(input longint x0, y0, x1, y1);
            longint p[6];
            longint dx, dy, ax, ay, s;
            dx = x1 - x0; dy = y1 - y0;
            p[0] = x0 * SC; p[1] = y0 * SC;
            p[2] = (x0 + x1) * (SC / 2); p[3] = (y0 + y1) * (SC / 2);
            p[4] = x1 * SC; p[5] = y1 * SC;
            if (dx != 0 && dy != 0) begin
                ax = dx < 0 ? -dx : dx;
                ay = dy < 0 ? -dy : dy;
                s = ax * ax + ay * ay;
                p[2] += dy > 0 ? -push(ay, s) : push(ay, s);
                p[3] += dx > 0 ? push(ax, s) : -push(ax, s);
            end
            add_curve(p);
        endfunction

        function void note_command(input otq_pkg::in_word_t c);
            longint ex, ey, ax, ay, bx, by, mx, my;
            longint p[6];
            int before_n;
            before_n = pending.size();
            ex = c.end_x; ey = c.end_y; ax = c.ctrl_a_x; ay = c.ctrl_a_y;
            bx = c.ctrl_b_x; by = c.ctrl_b_y;
            case (c.opcode)
                otq_pkg::OP_MOVE, otq_pkg::OP_END: begin
                    if (open && (cur_x != org_x || cur_y != org_y))
                        add_line(cur_x, cur_y, org_x, org_y);
                    if (c.opcode == otq_pkg::OP_MOVE) begin
                        cur_x = ex; org_x = ex; cur_y = ey; org_y = ey; open = 1;
                    end else begin
                        cur_x = 0; cur_y = 0; org_x = 0; org_y = 0; open = 0;
                    end
                end
                otq_pkg::OP_LINE: begin
                    add_line(cur_x, cur_y, ex, ey);
                    cur_x = ex; cur_y = ey;
                end
                otq_pkg::OP_QUAD: begin
                    p = '{cur_x * SC, cur_y * SC, ax * SC, ay * SC, ex * SC, ey * SC};
                    add_curve(p);
                    cur_x = ex; cur_y = ey;
                end
                otq_pkg::OP_CUBIC: begin
                    mx = (cur_x + 3 * ax + 3 * bx + ex) * (SC / 8);
                    my = (cur_y + 3 * ay + 3 * by + ey) * (SC / 8);
                    p = '{cur_x * SC, cur_y * SC, (cur_x + ax) * (SC / 2),
                          (cur_y + ay) * (SC / 2), mx, my};
                    add_curve(p);
                    p = '{mx, my, (ax + 2 * bx + ex) * (SC / 4),
                          (ay + 2 * by + ey) * (SC / 4), ex * SC, ey * SC};
                    add_curve(p);
                    cur_x = ex; cur_y = ey;
                end
                default: ;
            endcase
            if (pending.size() > before_n) pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_curve(input otq_pkg::out_word_t g);
            otq_pkg::out_word_t e;
            if (pending.size() == 0) begin
                report("unexpected curve, start_px", g.start_px, 0);
                return;
            end
            e = pending.pop_front();
            if (g.start_px != e.start_px) report("start_px", g.start_px, e.start_px);
            if (g.start_py != e.start_py) report("start_py", g.start_py, e.start_py);
            if (g.mid_px != e.mid_px) report("mid_px", g.mid_px, e.mid_px);
            if (g.mid_py != e.mid_py) report("mid_py", g.mid_py, e.mid_py);
            if (g.stop_px != e.stop_px) report("stop_px", g.stop_px, e.stop_px);
            if (g.stop_py != e.stop_py) report("stop_py", g.stop_py, e.stop_py);
            if (g.hband_lo != e.hband_lo) report("hband_lo", g.hband_lo, e.hband_lo);
            if (g.hband_hi != e.hband_hi) report("hband_hi", g.hband_hi, e.hband_hi);
            if (g.vband_lo != e.vband_lo) report("vband_lo", g.vband_lo, e.vband_lo);
            if (g.vband_hi != e.vband_hi) report("vband_hi", g.vband_hi, e.vband_hi);
            if (g.bands_valid != e.bands_valid)
                report("bands_valid", g.bands_valid, e.bands_valid);
            if (g.last != e.last) report("last", g.last, e.last);
        endfunction
    endclass

    curve_scoreboard board = new();

    // The receiver stalls in runs whose style changes at random.
    int stall_mode = 0;
    int stall_left = 0;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_curve(m_data);
        if ($urandom_range(0, 299) == 0) stall_mode = $urandom_range(0, 2);
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (stall_mode != 0 && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, stall_mode == 1 ? 3 : 20);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    int burst_left = 0;

    task automatic send_command(input otq_pkg::in_word_t c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= c;
        do @(posedge aclk); while (!s_ready);
        board.note_command(c);
    endtask

    task automatic write_box(input logic [otq_pkg::REG_IDX_W-1:0] idx, input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        board.set_box(idx, v);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic set_box_all(input logic [15:0] x0, y0, x1, y1);
        drain();
        write_box(otq_pkg::REG_BOX_X_MIN, x0);
        write_box(otq_pkg::REG_BOX_Y_MIN, y0);
        write_box(otq_pkg::REG_BOX_X_MAX, x1);
        write_box(otq_pkg::REG_BOX_Y_MAX, y1);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_coord(input int span);
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    function automatic otq_pkg::in_word_t make_command(input logic [2:0] op, input int span);
        otq_pkg::in_word_t c;
        c.opcode = op;
        c.end_x = pick_coord(span); c.end_y = pick_coord(span);
        c.ctrl_a_x = pick_coord(span); c.ctrl_a_y = pick_coord(span);
        c.ctrl_b_x = pick_coord(span); c.ctrl_b_y = pick_coord(span);
        return c;
    endfunction

    task automatic random_outlines(input int count, input int span);
        int r;
        logic [2:0] op;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10) op = otq_pkg::OP_MOVE;
            else if (r < 45) op = otq_pkg::OP_LINE;
            else if (r < 65) op = otq_pkg::OP_QUAD;
            else if (r < 85) op = otq_pkg::OP_CUBIC;
            else if (r < 92) op = otq_pkg::OP_END;
            else op = 3'($urandom_range(5, 7));
            send_command(make_command(op, span));
        end
    endtask

    otq_pkg::in_word_t cmd;

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: line without move, degenerate line, empty box, extremes, invalid opcodes.
        cmd = '0;
        cmd.opcode = otq_pkg::OP_LINE; cmd.end_x = 16'sd10; cmd.end_y = 16'sd0;
        send_command(cmd);
        send_command(cmd);
        cmd.opcode = otq_pkg::OP_END;
        send_command(cmd);
        set_box_all(16'sd0, 16'sd0, 16'sd1000, 16'sd1000);
        cmd = '0;
        cmd.opcode = otq_pkg::OP_MOVE; cmd.end_x = 16'sd100; cmd.end_y = 16'sd100;
        send_command(cmd);
        cmd.opcode = otq_pkg::OP_LINE; cmd.end_x = 16'sd500; cmd.end_y = 16'sd700;
        send_command(cmd);
        cmd.opcode = otq_pkg::OP_QUAD; cmd.ctrl_a_x = 16'sd900; cmd.ctrl_a_y = -16'sd50;
        cmd.end_x = 16'sd100; cmd.end_y = 16'sd900;
        send_command(cmd);
        cmd.opcode = otq_pkg::OP_CUBIC; cmd.ctrl_b_x = 16'sd2000; cmd.ctrl_b_y = 16'sd3;
        cmd.end_x = -16'sd7; cmd.end_y = 16'sd1;
        send_command(cmd);
        cmd.opcode = otq_pkg::OP_MOVE; cmd.end_x = 16'sh7FFF; cmd.end_y = 16'sh8000;
        send_command(cmd);
        cmd.opcode = otq_pkg::OP_LINE; cmd.end_x = 16'sh8000; cmd.end_y = 16'sh7FFF;
        send_command(cmd);
        cmd.opcode = otq_pkg::OP_CUBIC; cmd.ctrl_a_x = 16'sh7FFF; cmd.ctrl_a_y = 16'sh7FFF;
        cmd.ctrl_b_x = 16'sh7FFF; cmd.ctrl_b_y = 16'sh8000; cmd.end_x = 16'sh8000;
        cmd.end_y = 16'sh8000;
        send_command(cmd);
        cmd.opcode = otq_pkg::OP_MOVE; cmd.end_x = 16'sd1; cmd.end_y = 16'sd1;
        send_command(cmd);
        send_command(cmd);
        cmd.opcode = 3'd5;
        send_command(cmd);
        cmd.opcode = 3'd7;
        send_command(cmd);
        cmd.opcode = otq_pkg::OP_END;
        send_command(cmd);
        send_command(cmd);

        set_box_all(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
        random_outlines(120, 32767);
        set_box_all(16'sd0, 16'sd0, 16'sd1000, 16'sd1000);
        random_outlines(140, 1200);
        set_box_all(16'sd10, 16'sd10, 16'sd10, 16'sd50);
        random_outlines(40, 100);
        set_box_all(-16'sd200, 16'sd50, -16'sd100, 16'sd51);
        random_outlines(100, 300);
        set_box_all(16'sd500, 16'sd500, -16'sd500, -16'sd500);
        random_outlines(40, 32767);
        cmd = '0;
        cmd.opcode = otq_pkg::OP_END;
        send_command(cmd);

        drain();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: files.f
src/otq_pkg.sv
src/otq_push.sv
src/otq_band.sv
src/outline_to_quadratic_curves_core.sv
src/otq_checker.sv
bench/tb_outline_to_quadratic_curves_core.sv
